[design/tlc_pkg.sv]
// package: types, constants and helper functions for the traffic light controller core
`default_nettype none
package tlc_pkg;

   localparam int unsigned DUR_W = 7;
   localparam int unsigned CNT_W = 8;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W = 8;
   localparam int unsigned LAMP_W = 3;
   localparam int unsigned DIGITS = 4;
   localparam int unsigned SCAN_W = 2;
   localparam int unsigned SEG_W = 8;
   localparam int unsigned BCD_W = 4;

   localparam logic [DUR_W-1:0] DUR_MAX = 7'd99;
   localparam logic [DUR_W-1:0] DUR_MIN = 7'd1;

   localparam logic [DUR_W-1:0] RST_GREEN_A = 7'd24;
   localparam logic [DUR_W-1:0] RST_YELLOW_A = 7'd4;
   localparam logic [DUR_W-1:0] RST_RED_A = 7'd26;
   localparam logic [DUR_W-1:0] RST_GREEN_B = 7'd22;
   localparam logic [DUR_W-1:0] RST_YELLOW_B = 7'd4;
   localparam logic [DUR_W-1:0] RST_RED_B = 7'd26;
   localparam logic [CNT_W-1:0] RST_TICK_DIV = 8'd50;
   localparam logic [CNT_W-1:0] RST_BLINK_HALF = 8'd50;

   localparam logic [LAMP_W-1:0] LAMP_RED = 3'b001;
   localparam logic [LAMP_W-1:0] LAMP_YELLOW = 3'b010;
   localparam logic [LAMP_W-1:0] LAMP_GREEN = 3'b100;
   localparam logic [LAMP_W-1:0] LAMP_OFF = 3'b000;
   localparam logic [SEG_W-1:0] SEG_BLANK = 8'hFF;
   localparam logic [DIGITS-1:0] DIGIT_NONE = 4'b0000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_GREEN_A = 3'd0,
      REG_YELLOW_A = 3'd1,
      REG_RED_A = 3'd2,
      REG_GREEN_B = 3'd3,
      REG_YELLOW_B = 3'd4,
      REG_RED_B = 3'd5,
      REG_TICK_DIV = 3'd6,
      REG_BLINK_HALF = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      COL_GREEN = 2'd0,
      COL_YELLOW = 2'd1,
      COL_RED = 2'd2
   } colour_type;

   typedef struct packed {
      colour_type colour;
      logic [DUR_W-1:0] remain;
   } phase_type;

   function automatic logic [DUR_W-1:0] clamp_dur(input logic [DUR_W-1:0] d);
      logic [DUR_W-1:0] r;
      begin
         if (d < DUR_MIN) begin
            r = DUR_MIN;
         end else if (d > DUR_MAX) begin
            r = DUR_MAX;
         end else begin
            r = d;
         end
         return r;
      end
   endfunction

   function automatic logic [CNT_W-1:0] reload_of(input logic [CNT_W-1:0] v);
      return (v == '0) ? CNT_W'(1) : v;
   endfunction

   function automatic logic [LAMP_W-1:0] lamp_bits(input colour_type c);
      logic [LAMP_W-1:0] r;
      begin
         unique case (c)
            COL_GREEN: r = LAMP_GREEN;
            COL_YELLOW: r = LAMP_YELLOW;
            default: r = LAMP_RED;
         endcase
         return r;
      end
   endfunction

   function automatic phase_type count_one(input phase_type p,
                                           input logic [DUR_W-1:0] g,
                                           input logic [DUR_W-1:0] y,
                                           input logic [DUR_W-1:0] r);
      phase_type n;
      begin
         n = p;
         if (p.remain > DUR_MIN) begin
            n.remain = p.remain - DUR_MIN;
         end else begin
            unique case (p.colour)
               COL_GREEN: begin
                  n.colour = COL_YELLOW;
                  n.remain = clamp_dur(y);
               end
               COL_YELLOW: begin
                  n.colour = COL_RED;
                  n.remain = clamp_dur(r);
               end
               default: begin
                  n.colour = COL_GREEN;
                  n.remain = clamp_dur(g);
               end
            endcase
         end
         return n;
      end
   endfunction

   // tens digit of a value below 100 by reciprocal multiply
   function automatic logic [BCD_W-1:0] tens_of(input logic [DUR_W-1:0] v);
      logic [DUR_W+CNT_W-1:0] prod;
      begin
         prod = (DUR_W+CNT_W)'(v) * (DUR_W+CNT_W)'(205);
         return BCD_W'(prod >> 11);
      end
   endfunction

   function automatic logic [BCD_W-1:0] ones_of(input logic [DUR_W-1:0] v,
                                                input logic [BCD_W-1:0] t);
      logic [DUR_W-1:0] tx10;
      begin
         tx10 = DUR_W'({t, 3'b000}) + DUR_W'({t, 1'b0});
         return BCD_W'(v - tx10);
      end
   endfunction

   function automatic logic [SEG_W-1:0] seg_font(input logic [BCD_W-1:0] d);
      logic [SEG_W-1:0] s;
      begin
         unique case (d)
            4'd0: s = 8'hC0;
            4'd1: s = 8'hF9;
            4'd2: s = 8'hA4;
            4'd3: s = 8'hB0;
            4'd4: s = 8'h99;
            4'd5: s = 8'h92;
            4'd6: s = 8'h82;
            4'd7: s = 8'hF8;
            4'd8: s = 8'h80;
            default: s = 8'h90;
         endcase
         return s;
      end
   endfunction

endpackage
`default_nettype wire

[design/two_way_traffic_light_controller_core.sv]
// a result is registered in the cycle after its tick transaction is accepted, in one pass
// throughput: one tick transaction per cycle unless a result not yet taken stalls input
// the result register is freed in the same cycle it is taken, so input and output overlap
// reset: direction one green, direction two red, normal mode, registers to defaults
// reset is synchronous and active high; the block is ready in the cycle after reset
`default_nettype none
module two_way_traffic_light_controller_core (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic req_sleep_press,
   input  wire logic req_resume_press,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic [tlc_pkg::LAMP_W-1:0] rsp_lamps_a,
   output logic [tlc_pkg::LAMP_W-1:0] rsp_lamps_b,
   output logic [tlc_pkg::DIGITS-1:0] rsp_digit_enable,
   output logic [tlc_pkg::SEG_W-1:0] rsp_segments,
   output logic rsp_sleeping,
   input  wire logic csr_valid,
   output logic csr_ready,
   input  wire logic [tlc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [tlc_pkg::CSR_DATA_W-1:0] csr_data
);

   logic [tlc_pkg::DUR_W-1:0] green_a_ff, yellow_a_ff, red_a_ff;
   logic [tlc_pkg::DUR_W-1:0] green_b_ff, yellow_b_ff, red_b_ff;
   logic [tlc_pkg::CNT_W-1:0] tick_div_ff, blink_half_ff;

   logic mode_sleep_ff, mode_sleep_in;
   logic [tlc_pkg::CNT_W-1:0] prescale_ff, prescale_in;
   tlc_pkg::phase_type phase_a_ff, phase_a_in, phase_b_ff, phase_b_in;
   logic [tlc_pkg::SCAN_W-1:0] scan_ff, scan_in, scan_mid;
   logic [tlc_pkg::CNT_W-1:0] blink_count_ff, blink_count_in;
   logic blink_on_ff, blink_on_in;

   logic rsp_valid_ff;
   logic [tlc_pkg::LAMP_W-1:0] lamps_a_ff, lamps_a_in, lamps_b_ff, lamps_b_in;
   logic [tlc_pkg::DIGITS-1:0] digit_en_ff, digit_en_in;
   logic [tlc_pkg::SEG_W-1:0] segments_ff, segments_in;
   logic sleeping_ff;

   logic accept;
   logic [tlc_pkg::DUR_W-1:0] shown_a, shown_b, shown_sel;
   logic [tlc_pkg::BCD_W-1:0] tens_sel, ones_sel, digit;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         green_a_ff <= tlc_pkg::RST_GREEN_A;
         yellow_a_ff <= tlc_pkg::RST_YELLOW_A;
         red_a_ff <= tlc_pkg::RST_RED_A;
         green_b_ff <= tlc_pkg::RST_GREEN_B;
         yellow_b_ff <= tlc_pkg::RST_YELLOW_B;
         red_b_ff <= tlc_pkg::RST_RED_B;
         tick_div_ff <= tlc_pkg::RST_TICK_DIV;
         blink_half_ff <= tlc_pkg::RST_BLINK_HALF;
      end else if (csr_valid) begin
         unique case (tlc_pkg::csr_index_type'(csr_index))
            tlc_pkg::REG_GREEN_A: green_a_ff <= csr_data[tlc_pkg::DUR_W-1:0];
            tlc_pkg::REG_YELLOW_A: yellow_a_ff <= csr_data[tlc_pkg::DUR_W-1:0];
            tlc_pkg::REG_RED_A: red_a_ff <= csr_data[tlc_pkg::DUR_W-1:0];
            tlc_pkg::REG_GREEN_B: green_b_ff <= csr_data[tlc_pkg::DUR_W-1:0];
            tlc_pkg::REG_YELLOW_B: yellow_b_ff <= csr_data[tlc_pkg::DUR_W-1:0];
            tlc_pkg::REG_RED_B: red_b_ff <= csr_data[tlc_pkg::DUR_W-1:0];
            tlc_pkg::REG_TICK_DIV: tick_div_ff <= csr_data;
            default: blink_half_ff <= csr_data;
         endcase
      end
   end

   // mode, blink and countdown update
   always_comb begin
      mode_sleep_in = mode_sleep_ff;
      prescale_in = prescale_ff;
      phase_a_in = phase_a_ff;
      phase_b_in = phase_b_ff;
      scan_mid = scan_ff;
      blink_count_in = blink_count_ff;
      blink_on_in = blink_on_ff;
      if (accept) begin
         priority if (!mode_sleep_ff && req_sleep_press) begin
            mode_sleep_in = 1'b1;
            blink_count_in = blink_half_ff;
            blink_on_in = 1'b0;
         end else if (mode_sleep_ff && req_resume_press) begin
            mode_sleep_in = 1'b0;
            prescale_in = tick_div_ff;
            phase_a_in.colour = tlc_pkg::COL_GREEN;
            phase_a_in.remain = tlc_pkg::clamp_dur(green_a_ff);
            phase_b_in.colour = tlc_pkg::COL_RED;
            phase_b_in.remain = tlc_pkg::clamp_dur(red_b_ff);
            scan_mid = '0;
         end else if (mode_sleep_ff) begin
            if (blink_count_ff <= tlc_pkg::CNT_W'(1)) begin
               blink_on_in = !blink_on_ff;
               blink_count_in = tlc_pkg::reload_of(blink_half_ff);
            end else begin
               blink_count_in = blink_count_ff - tlc_pkg::CNT_W'(1);
            end
         end else begin
            if (prescale_ff <= tlc_pkg::CNT_W'(1)) begin
               prescale_in = tlc_pkg::reload_of(tick_div_ff);
               phase_a_in = tlc_pkg::count_one(phase_a_ff, green_a_ff, yellow_a_ff, red_a_ff);
               phase_b_in = tlc_pkg::count_one(phase_b_ff, green_b_ff, yellow_b_ff, red_b_ff);
            end else begin
               prescale_in = prescale_ff - tlc_pkg::CNT_W'(1);
            end
         end
      end
   end

   // display and lamp result
   always_comb begin
      shown_a = tlc_pkg::clamp_dur(phase_a_in.remain) - tlc_pkg::DUR_MIN;
      shown_b = tlc_pkg::clamp_dur(phase_b_in.remain) - tlc_pkg::DUR_MIN;
      shown_sel = scan_mid[1] ? shown_b : shown_a;
      tens_sel = tlc_pkg::tens_of(shown_sel);
      ones_sel = tlc_pkg::ones_of(shown_sel, tens_sel);
      digit = scan_mid[0] ? ones_sel : tens_sel;
      scan_in = scan_mid;
      if (mode_sleep_in) begin
         lamps_a_in = blink_on_in ? tlc_pkg::LAMP_YELLOW : tlc_pkg::LAMP_OFF;
         lamps_b_in = lamps_a_in;
         digit_en_in = tlc_pkg::DIGIT_NONE;
         segments_in = tlc_pkg::SEG_BLANK;
      end else begin
         lamps_a_in = tlc_pkg::lamp_bits(phase_a_in.colour);
         lamps_b_in = tlc_pkg::lamp_bits(phase_b_in.colour);
         digit_en_in = tlc_pkg::DIGITS'(1) << scan_mid;
         segments_in = tlc_pkg::seg_font(digit);
         if (accept) begin
            scan_in = scan_mid + tlc_pkg::SCAN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_sleep_ff <= 1'b0;
         prescale_ff <= tlc_pkg::RST_TICK_DIV;
         phase_a_ff.colour <= tlc_pkg::COL_GREEN;
         phase_a_ff.remain <= tlc_pkg::RST_GREEN_A;
         phase_b_ff.colour <= tlc_pkg::COL_RED;
         phase_b_ff.remain <= tlc_pkg::RST_RED_B;
         scan_ff <= '0;
         blink_count_ff <= tlc_pkg::RST_BLINK_HALF;
         blink_on_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_sleep_ff <= mode_sleep_in;
         prescale_ff <= prescale_in;
         phase_a_ff <= phase_a_in;
         phase_b_ff <= phase_b_in;
         scan_ff <= scan_in;
         blink_count_ff <= blink_count_in;
         blink_on_ff <= blink_on_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         lamps_a_ff <= lamps_a_in;
         lamps_b_ff <= lamps_b_in;
         digit_en_ff <= digit_en_in;
         segments_ff <= segments_in;
         sleeping_ff <= mode_sleep_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_lamps_a = lamps_a_ff;
   assign rsp_lamps_b = lamps_b_ff;
   assign rsp_digit_enable = digit_en_ff;
   assign rsp_segments = segments_ff;
   assign rsp_sleeping = sleeping_ff;

endmodule
`default_nettype wire
